// ----- rtl/core/sirt_pkg.sv -----
// ============================================================================
// sirt_pkg
// Shared types and constants of the swap-in reassembly table.
// ============================================================================
package sirt_pkg;

  localparam int ID_W   = 16;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int BYTE_W = 8;

  // Input opcodes
  localparam logic [1:0] OP_REQUEST  = 2'd0;
  localparam logic [1:0] OP_RESPONSE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_MEM    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Swap-in command byte and the beat that closes a request's byte burst
  localparam logic [BYTE_W-1:0] CMD_SWAP_IN = 8'h08;
  localparam logic [1:0]        BEAT_FIRST  = 2'd0;
  localparam logic [1:0]        BEAT_LAST   = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Per-slot record kept in the slot RAM
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] offset;
  } slot_rec_t;

endpackage

// ----- rtl/core/sirt_item_if.sv -----
// ============================================================================
// sirt_item_if
// Input channel: valid/ready handshake with one command item as payload.
// ============================================================================
interface sirt_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] buffer_id;
  logic [31:0] target_address;
  logic [15:0] target_size;
  logic [7:0]  payload_byte;
  logic        packet_end;

  modport source (
    output valid, opcode, buffer_id, target_address, target_size,
           payload_byte, packet_end,
    input  ready
  );

  modport sink (
    input  valid, opcode, buffer_id, target_address, target_size,
           payload_byte, packet_end,
    output ready
  );
endinterface

// ----- rtl/core/sirt_result_if.sv -----
// ============================================================================
// sirt_result_if
// Output channel: valid/ready handshake with one result item as payload.
// ============================================================================
interface sirt_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        write_enable;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic        pending;
  logic        table_full;
  logic        last;

  modport source (
    output valid, kind, tx_byte, write_enable, write_address, write_data,
           pending, table_full, last,
    input  ready
  );

  modport sink (
    input  valid, kind, tx_byte, write_enable, write_address, write_data,
           pending, table_full, last,
    output ready
  );
endinterface

// ----- rtl/core/sirt_ram.sv -----
// ============================================================================
// sirt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sirt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/sirt_tags.sv -----
// ============================================================================
// sirt_tags
// Slot valid bits and buffer-number tags with parallel match and
// lowest-index encoders for the matching slot and the first free slot.
// ============================================================================
module sirt_tags import sirt_pkg::*; #(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ID_W-1:0]    lookup_id,
  input  logic               alloc,
  input  logic               clear,
  input  logic [IDX_W-1:0]   slot,
  input  logic [ID_W-1:0]    alloc_id,
  output logic [ENTRIES-1:0] match,
  output logic               hit,
  output logic [IDX_W-1:0]   match_slot,
  output logic               has_free,
  output logic [IDX_W-1:0]   free_slot
);

  logic [ENTRIES-1:0] valid;
  logic [ID_W-1:0]    tag [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (alloc) begin
        valid[slot] <= 1'b1;
      end
      if (clear) begin
        valid[slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      tag[slot] <= alloc_id;
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      match[k] = valid[k] && (tag[k] == lookup_id);
    end
  end

  // Lowest index wins: scan downward so the last hit taken is the lowest
  always_comb begin
    match_slot = '0;
    free_slot  = '0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        match_slot = IDX_W'(k);
      end
      if (!valid[k]) begin
        free_slot = IDX_W'(k);
      end
    end
  end

  assign hit      = |match;
  assign has_free = ~&valid;

endmodule

// ----- rtl/core/swap_in_reassembly_table_unit.sv -----
// ============================================================================
// swap_in_reassembly_table_unit
// Pending swap-in request table: allocates slots for requests, steers
// response payload bytes to base plus offset, answers pending queries.
// ============================================================================
//
//  Channel   Dir  Payload                                        Per item
//  --------  ---  ---------------------------------------------  ----------
//  items     in   opcode, buffer_id, target_address,             1
//                 target_size, payload_byte, packet_end
//  results   out  kind, tx_byte, write_enable, write_address,    1 or 3
//                 write_data, pending, table_full, last
//
//  Each transaction has a lookup step, matching the buffer number against the
//  tag array and launching the slot RAM read, and an execute step, updating
//  the record from the registered RAM data and loading the output register.
//  A new item is taken once the output register is empty or drains its final
//  beat; a request occupies it for three beats (command, id high, id low).
//  Reset clears the slot valid bits and all control state at once; the slot
//  RAM needs no clearing pass since an invalid slot's record is never used.
//  A stalled results channel holds the output register and blocks new items.
//
module swap_in_reassembly_table_unit import sirt_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic           clk,
  input  logic           rst,
  sirt_item_if.sink      items,
  sirt_result_if.source  results
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int REC_W = $bits(slot_rec_t);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic in_take;
  logic out_free;

  // Latched item and lookup results
  logic [1:0]         op_q;
  logic [ID_W-1:0]    id_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SIZE_W-1:0]  size_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               end_q;
  logic [ENTRIES-1:0] match_q;
  logic               hit_q;
  logic               free_q;
  logic [IDX_W-1:0]   slot_q;

  // Tag array
  logic [ENTRIES-1:0] t_match;
  logic               t_hit;
  logic [IDX_W-1:0]   t_match_slot;
  logic               t_has_free;
  logic [IDX_W-1:0]   t_free_slot;
  logic               tag_alloc;
  logic               tag_clear;

  // Slot RAM
  logic             ram_we;
  logic [REC_W-1:0] ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  slot_rec_t        rec;
  slot_rec_t        rec_next;

  // Record update
  logic              room;
  logic [SIZE_W-1:0] off_next;
  logic [ADDR_W-1:0] wr_addr;
  logic              slot_done;
  logic [ENTRIES-1:0] clear_mask;
  logic              pend_after;

  // Output register
  logic              out_valid;
  logic [1:0]        out_beat;
  logic [1:0]        out_kind;
  logic [BYTE_W-1:0] out_tx;
  logic              out_we;
  logic [ADDR_W-1:0] out_waddr;
  logic [BYTE_W-1:0] out_wdata;
  logic              out_pend;
  logic              out_full;
  logic              out_last;
  logic              out_adv;

  // --------------------------------------------------------------------------
  // State machine
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Accept only when the output register is empty or drains its final beat
  assign out_free = !out_valid || (results.ready && out_last);

  always_comb begin
    items.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        items.ready = out_free;
      end
      ST_EXEC: begin
        items.ready = 1'b0;
      end
      default: begin
        items.ready = 1'b0;
      end
    endcase
  end

  assign in_take = items.valid && items.ready;

  // --------------------------------------------------------------------------
  // Lookup stage: match tags, latch the item, launch the RAM read
  // --------------------------------------------------------------------------
  sirt_tags #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_tags (
    .clk        (clk),
    .rst        (rst),
    .lookup_id  (items.buffer_id),
    .alloc      (tag_alloc),
    .clear      (tag_clear),
    .slot       (slot_q),
    .alloc_id   (id_q),
    .match      (t_match),
    .hit        (t_hit),
    .match_slot (t_match_slot),
    .has_free   (t_has_free),
    .free_slot  (t_free_slot)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q    <= items.opcode;
      id_q    <= items.buffer_id;
      addr_q  <= items.target_address;
      size_q  <= items.target_size;
      byte_q  <= items.payload_byte;
      end_q   <= items.packet_end;
      match_q <= t_match;
      hit_q   <= t_hit;
      free_q  <= t_has_free;
      // Request targets the first free slot, everything else the first match
      slot_q  <= (items.opcode == OP_REQUEST) ? t_free_slot : t_match_slot;
    end
  end

  sirt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (ram_wdata),
    .re    (in_take),
    .raddr (t_match_slot),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Execute stage: modify the record and write it back
  // --------------------------------------------------------------------------
  assign rec       = slot_rec_t'(ram_rdata);
  assign room      = rec.offset < rec.size;
  assign off_next  = room ? (rec.offset + SIZE_W'(1)) : rec.offset;
  assign wr_addr   = rec.base + ADDR_W'(rec.offset);
  assign slot_done = off_next >= rec.size;

  // Allocate on a request that found a free slot; free a finished slot at packet end
  assign tag_alloc = (state == ST_EXEC) && (op_q == OP_REQUEST) && free_q;
  assign tag_clear = (state == ST_EXEC) && (op_q == OP_RESPONSE) && hit_q &&
                     end_q && slot_done;

  always_comb begin
    rec_next.base   = rec.base;
    rec_next.size   = rec.size;
    rec_next.offset = off_next;
    if (tag_alloc) begin
      rec_next.base   = addr_q;
      rec_next.size   = size_q;
      rec_next.offset = '0;
    end
  end

  assign ram_we    = tag_alloc ||
                     ((state == ST_EXEC) && (op_q == OP_RESPONSE) && hit_q);
  assign ram_wdata = REC_W'(rec_next);

  // Pending after the step: drop the slot being freed from the match set
  assign clear_mask = tag_clear ? (ENTRIES'(1) << slot_q) : '0;
  assign pend_after = |(match_q & ~clear_mask);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign out_adv = out_valid && results.ready && !out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_beat  <= BEAT_FIRST;
    end else if (state == ST_EXEC) begin
      out_valid <= 1'b1;
      out_beat  <= BEAT_FIRST;
    end else if (out_adv) begin
      out_beat  <= out_beat + 2'd1;
    end else if (out_valid && results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      out_kind  <= KIND_MEM;
      out_tx    <= '0;
      out_we    <= 1'b0;
      out_waddr <= '0;
      out_wdata <= '0;
      out_pend  <= 1'b0;
      out_full  <= 1'b0;
      out_last  <= 1'b1;
      case (op_q)
        OP_REQUEST: begin
          if (free_q) begin
            out_kind <= KIND_TX;
            out_tx   <= CMD_SWAP_IN;
            out_pend <= 1'b1;
            out_last <= 1'b0;
          end else begin
            out_kind <= KIND_STATUS;
            out_full <= 1'b1;
            out_pend <= |match_q;
          end
        end
        OP_RESPONSE: begin
          if (hit_q) begin
            out_we    <= room;
            out_waddr <= room ? wr_addr : '0;
            out_wdata <= room ? byte_q : '0;
            out_pend  <= pend_after;
          end
        end
        OP_QUERY: begin
          out_kind <= KIND_STATUS;
          out_pend <= |match_q;
        end
        default: begin
          out_kind <= KIND_MEM;
        end
      endcase
    end else if (out_adv) begin
      // Advance through the id bytes of a request burst
      out_tx   <= (out_beat == BEAT_FIRST) ? id_q[ID_W-1:BYTE_W] : id_q[BYTE_W-1:0];
      out_last <= ((out_beat + 2'd1) == BEAT_LAST);
    end
  end

  assign results.valid         = out_valid;
  assign results.kind          = out_kind;
  assign results.tx_byte       = out_tx;
  assign results.write_enable  = out_we;
  assign results.write_address = out_waddr;
  assign results.write_data    = out_wdata;
  assign results.pending       = out_pend;
  assign results.table_full    = out_full;
  assign results.last          = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // Execute only ever loads an empty output register
  a_exec_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !out_valid)
    else $error("output register busy during execute");

  // An accepted transaction is executed in the next cycle
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_EXEC))
    else $error("accepted transaction not executed");

  // Memory writes only come out as memory-kind results, never with full
  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.write_enable) |->
      ((results.kind == KIND_MEM) && !results.table_full))
    else $error("write enable on a non-memory result");

  // Allocation never coincides with a release
  a_alloc_clear: assert property (@(posedge clk) disable iff (rst)
    tag_alloc |-> !tag_clear)
    else $error("slot allocated and freed together");
`endif

endmodule
